// ----- hdl/bad_pkg.sv -----
// Shared types, constants and helper functions for the box average downsampler.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package bad_pkg;

  // Input item codes.
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [3:0] SCALE_RESET = 4'd2;
  localparam logic [3:0] SCALE_MIN   = 4'd1;
  localparam logic [3:0] SCALE_MAX   = 4'd8;

  // Reciprocal of scale squared in Q16.
  localparam int RECIP_BITS = 17;
  localparam int FRAC_BITS  = 16;
  localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

  // Result queue at the output.
  localparam int FIFO_DEPTH    = 8;
  localparam int FIFO_PTR_BITS = 3;
  localparam int FIFO_CNT_BITS = 4;

  // Control that rides along with an item through the datapath.
  typedef struct packed {
    logic       emit;
    logic       row_end;
    logic       frame_end;
    logic [3:0] scale;
  } bad_tag_t;

  // One result beat.
  typedef struct packed {
    logic [15:0] avg_red;
    logic [15:0] avg_green;
    logic [15:0] avg_blue;
    logic        out_row_end;
    logic        out_frame_end;
  } bad_avg_t;

  function automatic logic [3:0] eff_scale(logic [3:0] value);
    logic [3:0] result;
    if (value == 4'd0) begin
      result = SCALE_MIN;
    end else if (value > SCALE_MAX) begin
      result = SCALE_MAX;
    end else begin
      result = value;
    end
    return result;
  endfunction

  function automatic logic [RECIP_BITS-1:0] recip_q16(logic [3:0] s);
    logic [RECIP_BITS-1:0] result;
    case (s)
      4'd2:    result = 17'd16384;
      4'd3:    result = 17'd7282;
      4'd4:    result = 17'd4096;
      4'd5:    result = 17'd2621;
      4'd6:    result = 17'd1820;
      4'd7:    result = 17'd1337;
      4'd8:    result = 17'd1024;
      default: result = 17'd65536;
    endcase
    return result;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/bad_if.sv -----
// Valid/ready channel interfaces of the box average downsampler: pixel input,
// average output and scale register writes. Depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

interface bad_pix_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] red;
  logic [15:0] green;
  logic [15:0] blue;
  logic        row_end;
  logic        frame_end;

  modport source (output valid, op, red, green, blue, row_end, frame_end, input ready);
  modport sink (input valid, op, red, green, blue, row_end, frame_end, output ready);
endinterface

interface bad_avg_if;
  logic        valid;
  logic        ready;
  logic [15:0] avg_red;
  logic [15:0] avg_green;
  logic [15:0] avg_blue;
  logic        out_row_end;
  logic        out_frame_end;

  modport source (output valid, avg_red, avg_green, avg_blue, out_row_end, out_frame_end,
                  input ready);
  modport sink (input valid, avg_red, avg_green, avg_blue, out_row_end, out_frame_end,
                output ready);
endinterface

interface bad_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] scale;

  modport source (output valid, scale, input ready);
  modport sink (input valid, scale, output ready);
endinterface

`default_nettype wire

// ----- hdl/bad_colmem.sv -----
// Column sum memory with read-modify-write, write forwarding and a clearing pass.
// Depends on bad_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bad_colmem #(
  parameter int MAX_OUT_COLUMNS = 512,
  parameter int SAMPLE_BITS     = 16,
  localparam int AW   = (MAX_OUT_COLUMNS > 1) ? $clog2(MAX_OUT_COLUMNS) : 1,
  localparam int SUMW = SAMPLE_BITS + 6
) (
  input  wire logic             clk,
  input  wire logic             rst,
  output logic                  busy,
  input  wire logic             req_valid,
  input  wire logic [AW-1:0]    req_addr,
  input  wire logic [SUMW-1:0]  req_red,
  input  wire logic [SUMW-1:0]  req_green,
  input  wire logic [SUMW-1:0]  req_blue,
  input  wire bad_pkg::bad_tag_t req_tag,
  output logic                  sum_valid,
  output logic [SUMW-1:0]       sum_red,
  output logic [SUMW-1:0]       sum_green,
  output logic [SUMW-1:0]       sum_blue,
  output bad_pkg::bad_tag_t     sum_tag
);

  localparam int WORDW = 3 * SUMW;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_OUT_COLUMNS - 1);

  logic [WORDW-1:0] mem [MAX_OUT_COLUMNS];
  logic [WORDW-1:0] rdata;

  logic              clearing;
  logic [AW-1:0]     clr_addr;

  logic              s1_valid;
  logic [AW-1:0]     s1_addr;
  logic [SUMW-1:0]   s1_red;
  logic [SUMW-1:0]   s1_green;
  logic [SUMW-1:0]   s1_blue;
  bad_pkg::bad_tag_t s1_tag;

  logic              fwd_hit;
  logic [WORDW-1:0]  fwd_data;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORDW-1:0]  wr_data;
  logic [WORDW-1:0]  base;

  // Sums clamp at all ones; such a sum saturates the average at every scale.
  function automatic logic [SUMW-1:0] sat_add(logic [SUMW-1:0] a, logic [SUMW-1:0] b);
    logic [SUMW:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[SUMW] ? '1 : t[SUMW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      rdata <= mem[req_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      s1_valid <= req_valid;
      // The read saw the old word when a write to the same column landed on the same edge.
      fwd_hit  <= req_valid && wr_en && (wr_addr == req_addr);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= wr_data;
    if (req_valid) begin
      s1_addr  <= req_addr;
      s1_red   <= req_red;
      s1_green <= req_green;
      s1_blue  <= req_blue;
      s1_tag   <= req_tag;
    end
  end

  always_comb begin
    base      = fwd_hit ? fwd_data : rdata;
    sum_red   = sat_add(base[3*SUMW-1:2*SUMW], s1_red);
    sum_green = sat_add(base[2*SUMW-1:SUMW], s1_green);
    sum_blue  = sat_add(base[SUMW-1:0], s1_blue);
    sum_valid = s1_valid && s1_tag.emit;
    sum_tag   = s1_tag;
    wr_en     = clearing || s1_valid;
    wr_addr   = clearing ? clr_addr : s1_addr;
    // An emitted column starts over from zero.
    if (clearing || s1_tag.emit) begin
      wr_data = '0;
    end else begin
      wr_data = {sum_red, sum_green, sum_blue};
    end
  end

  assign busy = clearing;

endmodule

`default_nettype wire

// ----- hdl/bad_scale_unit.sv -----
// Multiplies block sums by the Q16 reciprocal of scale squared, rounds and saturates.
// Two register stages; depends on bad_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bad_scale_unit #(
  parameter int SAMPLE_BITS = 16,
  localparam int SUMW = SAMPLE_BITS + 6
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [SUMW-1:0]   in_red,
  input  wire logic [SUMW-1:0]   in_green,
  input  wire logic [SUMW-1:0]   in_blue,
  input  wire bad_pkg::bad_tag_t in_tag,
  output logic [1:0]             occupancy,
  output logic                   out_valid,
  output bad_pkg::bad_avg_t      out_beat
);

  localparam int PW = SUMW + bad_pkg::RECIP_BITS;
  localparam int HW = PW + 1 - bad_pkg::FRAC_BITS;
  localparam logic [SAMPLE_BITS-1:0] SAT_MAX = '1;

  logic                        v2;
  logic [SUMW-1:0]             red2;
  logic [SUMW-1:0]             green2;
  logic [SUMW-1:0]             blue2;
  bad_pkg::bad_tag_t           tag2;
  logic [bad_pkg::RECIP_BITS-1:0] recip;

  logic                        v3;
  logic [PW-1:0]               prod_red;
  logic [PW-1:0]               prod_green;
  logic [PW-1:0]               prod_blue;
  bad_pkg::bad_tag_t           tag3;

  function automatic logic [SAMPLE_BITS-1:0] round_sat(logic [PW-1:0] p);
    logic [PW:0]   r;
    logic [HW-1:0] hi;
    r  = (PW + 1)'(p) + (PW + 1)'(bad_pkg::ROUND_HALF);
    hi = r[PW:bad_pkg::FRAC_BITS];
    return (hi > HW'(SAT_MAX)) ? SAT_MAX : hi[SAMPLE_BITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v2 <= in_valid;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      red2   <= in_red;
      green2 <= in_green;
      blue2  <= in_blue;
      tag2   <= in_tag;
    end
    if (v2) begin
      prod_red   <= PW'(red2) * PW'(recip);
      prod_green <= PW'(green2) * PW'(recip);
      prod_blue  <= PW'(blue2) * PW'(recip);
      tag3       <= tag2;
    end
  end

  always_comb begin
    recip                  = bad_pkg::recip_q16(tag2.scale);
    occupancy              = 2'(v2) + 2'(v3);
    out_valid              = v3;
    out_beat.avg_red       = 16'(round_sat(prod_red));
    out_beat.avg_green     = 16'(round_sat(prod_green));
    out_beat.avg_blue      = 16'(round_sat(prod_blue));
    out_beat.out_row_end   = tag3.row_end;
    out_beat.out_frame_end = tag3.frame_end;
  end

endmodule

`default_nettype wire

// ----- hdl/box_average_downsampler_top.sv -----
// Top level of the box average downsampler: position tracking, column memory,
// scaling stages and result queue. Depends on bad_pkg, bad_if, bad_colmem, bad_scale_unit.
//
// Usage:
//   pix carries raster-order RGB pixels (op pixel) and flush items (op flush) that
//   drain a partial last band one output column per beat. avg carries one
//   averaged pixel per finished block. cfg writes the scale register (1 to 8,
//   reset value 2) and is always ready; write it only while the block is idle.
//   One item is accepted per clock while pix.ready is high. A result beat is offered
//   after the beat that caused it has passed the column memory read, the
//   read-modify-write, the multiply and the rounding into the queue, in that order.
//   Column sums live in a single-port-write, registered-read memory; a write is
//   forwarded to a read of the same column issued on the same edge.
//   After reset the memory is cleared one column per cycle, all MAX_OUT_COLUMNS
//   columns, while pix.ready stays low.
//   Results wait in an 8-entry queue. When the receiver stalls, pix.ready drops
//   once the queue and the items in flight could fill it; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none

module box_average_downsampler_top #(
  parameter int MAX_OUT_COLUMNS = 512,
  parameter int SAMPLE_BITS     = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  bad_pix_if.sink   pix,
  bad_avg_if.source avg,
  bad_cfg_if.sink   cfg
);

  localparam int AW   = (MAX_OUT_COLUMNS > 1) ? $clog2(MAX_OUT_COLUMNS) : 1;
  localparam int CW   = $clog2(MAX_OUT_COLUMNS + 1);
  localparam int SUMW = SAMPLE_BITS + 6;
  localparam logic [CW-1:0] COL_LIMIT   = CW'(MAX_OUT_COLUMNS);
  localparam logic [15:0]   SAMPLE_MASK = 16'((64'd1 << SAMPLE_BITS) - 64'd1);

  logic [3:0]    scale;
  logic [2:0]    column_phase;
  logic [2:0]    row_phase;
  logic [CW-1:0] output_column;
  logic [CW-1:0] columns_in_row;
  logic [CW-1:0] flush_position;
  logic          flush_pending;

  logic       fire;
  logic       is_flush;
  logic [3:0] s_eff;
  logic       frame_end;
  logic       row_end;
  logic       last_row;
  logic       last_col;
  logic       in_range;
  logic       fl_ok;
  logic       fl_last;

  logic              req_valid;
  logic [AW-1:0]     req_addr;
  logic [SUMW-1:0]   req_red;
  logic [SUMW-1:0]   req_green;
  logic [SUMW-1:0]   req_blue;
  bad_pkg::bad_tag_t req_tag;

  logic              busy;
  logic              sum_valid;
  logic [SUMW-1:0]   sum_red;
  logic [SUMW-1:0]   sum_green;
  logic [SUMW-1:0]   sum_blue;
  bad_pkg::bad_tag_t sum_tag;

  logic [1:0]        occupancy;
  logic              push;
  bad_pkg::bad_avg_t push_beat;

  bad_pkg::bad_avg_t fifo_mem [bad_pkg::FIFO_DEPTH];
  logic [bad_pkg::FIFO_PTR_BITS-1:0] wr_ptr;
  logic [bad_pkg::FIFO_PTR_BITS-1:0] rd_ptr;
  logic [bad_pkg::FIFO_CNT_BITS-1:0] fifo_count;
  logic [bad_pkg::FIFO_CNT_BITS-1:0] inflight;
  logic              pop;
  bad_pkg::bad_avg_t head;

  // Configuration.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= bad_pkg::SCALE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      scale <= cfg.scale;
    end
  end

  // Every result that may still reach the queue has a slot reserved for it.
  assign inflight = fifo_count + bad_pkg::FIFO_CNT_BITS'(occupancy)
                    + bad_pkg::FIFO_CNT_BITS'(sum_valid);
  assign pix.ready = !busy && (inflight < bad_pkg::FIFO_CNT_BITS'(bad_pkg::FIFO_DEPTH));

  always_comb begin
    fire      = pix.valid && pix.ready;
    is_flush  = (pix.op == bad_pkg::OP_FLUSH);
    s_eff     = bad_pkg::eff_scale(scale);
    frame_end = pix.frame_end;
    row_end   = pix.row_end || pix.frame_end;
    last_row  = ({1'b0, row_phase} + 4'd1) >= s_eff;
    last_col  = ({1'b0, column_phase} + 4'd1) >= s_eff;
    in_range  = output_column < COL_LIMIT;
    fl_ok     = flush_pending && (flush_position < columns_in_row)
                && (flush_position < COL_LIMIT);
    fl_last   = ((CW + 1)'(flush_position) + (CW + 1)'(1)) >= (CW + 1)'(columns_in_row);

    req_valid = fire && (is_flush ? fl_ok : in_range);
    req_addr  = is_flush ? AW'(flush_position) : AW'(output_column);
    if (is_flush) begin
      req_red   = '0;
      req_green = '0;
      req_blue  = '0;
    end else begin
      req_red   = SUMW'(pix.red & SAMPLE_MASK);
      req_green = SUMW'(pix.green & SAMPLE_MASK);
      req_blue  = SUMW'(pix.blue & SAMPLE_MASK);
    end
    req_tag.emit      = is_flush || (last_row && (last_col || row_end));
    req_tag.row_end   = is_flush ? fl_last : row_end;
    req_tag.frame_end = is_flush ? fl_last : (row_end && frame_end);
    req_tag.scale     = s_eff;
  end

  // Position inside the raster and flush bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_phase   <= '0;
      row_phase      <= '0;
      output_column  <= '0;
      columns_in_row <= '0;
      flush_position <= '0;
      flush_pending  <= 1'b0;
    end else if (fire) begin
      if (is_flush) begin
        if (fl_ok) begin
          flush_position <= flush_position + CW'(1);
          if (fl_last) begin
            flush_pending <= 1'b0;
          end
        end else begin
          flush_pending <= 1'b0;
        end
      end else begin
        flush_pending <= 1'b0;
        if (row_end) begin
          columns_in_row <= in_range ? (output_column + CW'(1)) : COL_LIMIT;
          column_phase   <= '0;
          output_column  <= '0;
          if (frame_end) begin
            // A band cut short by the frame end is drained by flush items.
            if (!last_row) begin
              flush_pending  <= 1'b1;
              flush_position <= '0;
            end
            row_phase <= '0;
          end else begin
            row_phase <= last_row ? 3'd0 : (row_phase + 3'd1);
          end
        end else if (last_col) begin
          column_phase <= '0;
          if (in_range) begin
            output_column <= output_column + CW'(1);
          end
        end else begin
          column_phase <= column_phase + 3'd1;
        end
      end
    end
  end

  bad_colmem #(
    .MAX_OUT_COLUMNS (MAX_OUT_COLUMNS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_colmem (
    .clk       (clk),
    .rst       (rst),
    .busy      (busy),
    .req_valid (req_valid),
    .req_addr  (req_addr),
    .req_red   (req_red),
    .req_green (req_green),
    .req_blue  (req_blue),
    .req_tag   (req_tag),
    .sum_valid (sum_valid),
    .sum_red   (sum_red),
    .sum_green (sum_green),
    .sum_blue  (sum_blue),
    .sum_tag   (sum_tag)
  );

  bad_scale_unit #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_scale_unit (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sum_valid),
    .in_red    (sum_red),
    .in_green  (sum_green),
    .in_blue   (sum_blue),
    .in_tag    (sum_tag),
    .occupancy (occupancy),
    .out_valid (push),
    .out_beat  (push_beat)
  );

  // Result queue.
  assign pop  = avg.valid && avg.ready;
  assign head = fifo_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= push_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + bad_pkg::FIFO_PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + bad_pkg::FIFO_PTR_BITS'(1);
      end
      fifo_count <= fifo_count + bad_pkg::FIFO_CNT_BITS'(push)
                    - bad_pkg::FIFO_CNT_BITS'(pop);
    end
  end

  assign avg.valid         = (fifo_count != '0);
  assign avg.avg_red       = head.avg_red;
  assign avg.avg_green     = head.avg_green;
  assign avg.avg_blue      = head.avg_blue;
  assign avg.out_row_end   = head.out_row_end;
  assign avg.out_frame_end = head.out_frame_end;

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (fifo_count < bad_pkg::FIFO_CNT_BITS'(bad_pkg::FIFO_DEPTH)))
    else $error("result queue written while full");

  a_reserve_bound: assert property (@(posedge clk) disable iff (rst)
    inflight <= bad_pkg::FIFO_CNT_BITS'(bad_pkg::FIFO_DEPTH))
    else $error("more results in flight than queue slots");

  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    busy |-> !fire)
    else $error("item accepted during the memory clearing pass");

  a_frame_ends_row: assert property (@(posedge clk) disable iff (rst)
    (avg.valid && avg.out_frame_end) |-> avg.out_row_end)
    else $error("frame end beat without row end");

  a_flush_needs_pending: assert property (@(posedge clk) disable iff (rst)
    (req_valid && is_flush) |-> flush_pending)
    else $error("flush emitted with no flush pending");
`endif

endmodule

`default_nettype wire
